FILE: hw/rtl/mad_pkg.sv
// Shared types, constants and coefficient tables for the ADPCM stream decoder.
// No dependencies; every other file imports this package.
package mad_pkg;

	// Configuration port layout
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ALIGN = 2'd1;

	// Register reset values
	localparam logic [1:0]  CHANNELS_RST    = 2'd1;
	localparam logic [15:0] BLOCK_ALIGN_RST = 16'd256;

	// Highest predictor index and smallest legal step
	localparam logic [2:0]         PRED_MAX = 3'd6;
	localparam logic signed [15:0] STEP_MIN = 16'sd16;

	// Saturation bounds of the output sample
	localparam logic signed [20:0] SAMPLE_MAX = 21'sd32767;
	localparam logic signed [20:0] SAMPLE_MIN = -21'sd32768;

	typedef logic signed [10:0] coef_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;    // input transfer this cycle
		logic mul;     // form products for the current nibble
		logic acc;     // sum, clamp, write back and present a sample
		logic nib_lo;  // 0: high nibble, 1: low nibble
	} mad_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic hdr;       // the offered byte is a block header byte
		logic out_room;  // output register can take a sample this cycle
	} mad_sts_t;

	// First predictor coefficient (applied to the newer sample)
	function automatic coef_t coef_a(input logic [2:0] pi);
		coef_t c;
		unique case (pi)
			3'd0:    c = 11'sd256;
			3'd1:    c = 11'sd512;
			3'd2:    c = 11'sd0;
			3'd3:    c = 11'sd192;
			3'd4:    c = 11'sd240;
			3'd5:    c = 11'sd460;
			default: c = 11'sd392;
		endcase
		return c;
	endfunction

	// Second predictor coefficient (applied to the older sample)
	function automatic coef_t coef_b(input logic [2:0] pi);
		coef_t c;
		unique case (pi)
			3'd0:    c = 11'sd0;
			3'd1:    c = -11'sd256;
			3'd2:    c = 11'sd0;
			3'd3:    c = 11'sd64;
			3'd4:    c = 11'sd0;
			3'd5:    c = -11'sd208;
			default: c = -11'sd232;
		endcase
		return c;
	endfunction

	// Step adaptation factor, in 1/256 units
	function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
		logic [9:0] f;
		unique case (nib) inside
			4'd4, 4'd12: f = 10'd307;
			4'd5, 4'd11: f = 10'd409;
			4'd6, 4'd10: f = 10'd512;
			4'd7, 4'd9:  f = 10'd614;
			4'd8:        f = 10'd768;
			default:     f = 10'd230;
		endcase
		return f;
	endfunction

endpackage

FILE: hw/rtl/mad_stream_ifs.sv
// Handshake channel interfaces of the ADPCM stream decoder: byte input,
// sample output and configuration writes. Depends on mad_pkg.
interface mad_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       chunk_start;
	modport source (output valid, data_byte, chunk_start, input ready);
	modport sink   (input valid, data_byte, chunk_start, output ready);
endinterface

interface mad_pcm_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               channel;
	logic               last;
	modport source (output valid, sample, channel, last, input ready);
	modport sink   (input valid, sample, channel, last, output ready);
endinterface

interface mad_cfg_if import mad_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/mad_ctrl.sv
// Sequencing controller of the ADPCM decoder: byte intake, then a multiply
// and an accumulate step per nibble. Depends on mad_pkg.
module mad_ctrl import mad_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  mad_sts_t sts,
	output logic     in_ready,
	output mad_cmd_t cmd
);

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC} state_t;

	state_t state_q;
	logic   nib_q;

	// Commands
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.take   = in_ready && in_valid;
		cmd.mul    = (state_q == S_MUL);
		cmd.acc    = (state_q == S_ACC) && sts.out_room;
		cmd.nib_lo = nib_q;
	end

	// State and nibble select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nib_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !sts.hdr) begin
						state_q <= S_MUL;
						nib_q   <= 1'b0;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (sts.out_room) begin
						if (!nib_q) begin
							nib_q   <= 1'b1;
							state_q <= S_MUL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_acc_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> sts.out_room)
		else $error("accumulate issued with output register full");
	a_mul_then_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |=> (state_q == S_ACC))
		else $error("multiply step not followed by accumulate");
	a_hdr_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && sts.hdr) |=> (state_q == S_IDLE))
		else $error("header byte started a decode");
`endif

endmodule

FILE: hw/rtl/mad_datapath.sv
// Datapath of the ADPCM decoder: configuration, block position, header
// capture, per-channel history and step, products, clamp, output register.
// Depends on mad_pkg.
module mad_datapath import mad_pkg::*; #(
	parameter int MAX_CHANNELS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input payload
	input  logic [7:0]            data_byte,
	input  logic                  chunk_start,
	// control
	input  mad_cmd_t              cmd,
	output mad_sts_t              sts,
	// output
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    out_sample,
	output logic                  out_channel,
	output logic                  out_last
);

	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int HL_W = $clog2(7 * MAX_CHANNELS + 1);

	// Divide by 256 with truncation toward zero
	function automatic logic signed [27:0] div256(input logic signed [27:0] v);
		logic signed [27:0] r;
		r = v >>> 8;
		if (v[27] && (v[7:0] != 8'd0)) r = r + 28'sd1;
		return r;
	endfunction

	// Configuration and sequencing state
	logic [1:0]      chans_q;
	logic [15:0]     balign_q;
	logic [15:0]     pos_q;
	logic [CH_W-1:0] cur_ch_q;
	logic [7:0]      hlow_q;
	logic [7:0]      byte_q;

	// Per-channel decoder state
	logic [2:0]         pidx_q  [MAX_CHANNELS];
	logic signed [15:0] step_q  [MAX_CHANNELS];
	logic signed [15:0] newer_q [MAX_CHANNELS];
	logic signed [15:0] older_q [MAX_CHANNELS];

	// Products
	logic signed [26:0] pa_s1, pb_s1, pt_s1;
	logic signed [19:0] ps_s1;

	// Output register
	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic               out_channel_q;
	logic               out_last_q;

	// Active channel count
	logic [HL_W-1:0] nch;
	always_comb begin
		if (chans_q == 2'd0)
			nch = HL_W'(1);
		else if (HL_W'(chans_q) > HL_W'(MAX_CHANNELS))
			nch = HL_W'(MAX_CHANNELS);
		else
			nch = HL_W'(chans_q);
	end

	// Position of the offered byte and header decode
	logic [15:0]     pos_eff;
	logic [15:0]     pos_inc;
	logic [HL_W-1:0] hlen;
	logic [HL_W-1:0] hp, hq, hh, hch;
	logic [CH_W-1:0] ch_take;
	logic            is_hdr;
	always_comb begin
		pos_eff = chunk_start ? 16'd0 : pos_q;
		pos_inc = pos_eff + 16'd1;
		hlen    = HL_W'(7 * 1) * nch;
		is_hdr  = (pos_eff < 16'(hlen));
		hp      = pos_eff[HL_W-1:0];
		hq      = hp - nch;
		hh      = hq >> 1;
		if (hh < nch)
			hch = hh;
		else if (hh < (nch << 1))
			hch = hh - nch;
		else
			hch = hh - (nch << 1);
		if (chunk_start || (HL_W'(cur_ch_q) >= nch))
			ch_take = '0;
		else
			ch_take = cur_ch_q;
	end

	assign sts.hdr      = is_hdr;
	assign sts.out_room = !out_valid_q || out_ready;

	// Current nibble and channel state reads
	logic [3:0]         nib;
	logic signed [3:0]  nib_s;
	logic [2:0]         rd_pidx;
	logic signed [15:0] rd_step, rd_newer, rd_older;
	always_comb begin
		nib      = cmd.nib_lo ? byte_q[3:0] : byte_q[7:4];
		nib_s    = $signed(nib);
		rd_pidx  = pidx_q[cur_ch_q];
		rd_step  = step_q[cur_ch_q];
		rd_newer = newer_q[cur_ch_q];
		rd_older = older_q[cur_ch_q];
	end

	// Prediction, clamp and step adaptation
	logic signed [27:0] pred_sum, pred, tnew;
	logic signed [20:0] total;
	logic signed [15:0] sample_c, step_w, step_c;
	logic [HL_W-1:0]    ch_nxt;
	always_comb begin
		pred_sum = 28'(pa_s1) + 28'(pb_s1);
		pred     = div256(pred_sum);
		total    = 21'(pred) + 21'(ps_s1);
		if (total > SAMPLE_MAX)
			sample_c = SAMPLE_MAX[15:0];
		else if (total < SAMPLE_MIN)
			sample_c = SAMPLE_MIN[15:0];
		else
			sample_c = total[15:0];
		tnew   = div256(28'(pt_s1));
		step_w = tnew[15:0];
		step_c = (step_w < STEP_MIN) ? STEP_MIN : step_w;
		ch_nxt = HL_W'(cur_ch_q) + HL_W'(1);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chans_q     <= CHANNELS_RST;
			balign_q    <= BLOCK_ALIGN_RST;
			pos_q       <= '0;
			cur_ch_q    <= '0;
			hlow_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CHANNELS:    chans_q  <= cfg_data[1:0];
					CFG_BLOCK_ALIGN: balign_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.take) begin
				pos_q    <= (pos_inc == balign_q) ? 16'd0 : pos_inc;
				cur_ch_q <= ch_take;
				if (is_hdr && (hp >= nch) && !hq[0])
					hlow_q <= data_byte;
			end
			if (cmd.acc)
				cur_ch_q <= (ch_nxt < nch) ? ch_nxt[CH_W-1:0] : '0;
			if (cmd.acc)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Channel state, products and output payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= data_byte;
			if (is_hdr) begin
				if (hp < nch) begin
					pidx_q[hp[CH_W-1:0]] <= (data_byte > 8'(PRED_MAX)) ?
						PRED_MAX : data_byte[2:0];
				end else if (hq[0]) begin
					if (hh < nch)
						step_q[hch[CH_W-1:0]] <= {data_byte, hlow_q};
					else if (hh < (nch << 1))
						newer_q[hch[CH_W-1:0]] <= {data_byte, hlow_q};
					else
						older_q[hch[CH_W-1:0]] <= {data_byte, hlow_q};
				end
			end
		end
		if (cmd.mul) begin
			pa_s1 <= 27'(rd_newer) * 27'(coef_a(rd_pidx));
			pb_s1 <= 27'(rd_older) * 27'(coef_b(rd_pidx));
			ps_s1 <= 20'(nib_s) * 20'(rd_step);
			pt_s1 <= 27'($signed({1'b0, adapt_factor(nib)})) * 27'(rd_step);
		end
		if (cmd.acc) begin
			older_q[cur_ch_q] <= rd_newer;
			newer_q[cur_ch_q] <= sample_c;
			step_q[cur_ch_q]  <= step_c;
			out_sample_q      <= sample_c;
			out_channel_q     <= cur_ch_q[0];
			out_last_q        <= cmd.nib_lo;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign out_channel = out_channel_q;
	assign out_last    = out_last_q;

`ifndef SYNTHESIS
	a_out_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.acc))
		else $error("sample presented without an accumulate step");
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.acc)
		else $error("stalled sample overwritten");
`endif

endmodule

FILE: hw/rtl/ms_adpcm_stream_decoder_unit.sv
// Channel     | Direction | Payload                          | Transfer when
// adpcm       | in        | data_byte[7:0], chunk_start      | valid && ready
// pcm         | out       | sample[15:0] signed, channel, last | valid && ready
// cfg         | in        | index[1:0], data[15:0]           | valid && ready (ready tied high)
//
// A header byte needs only its intake step. A data byte takes intake, then
// a multiply and an accumulate step per nibble, set by the shared product
// stage and the dependence of each nibble on the previous sample and step.
// A sample waiting in the output register stalls the accumulate step only;
// the next byte is taken while the last sample of a byte waits.
// Reset (arst_n low, asynchronous) resets control state; channel history is
// loaded by block headers.
// Depends on mad_pkg, mad_stream_ifs, mad_ctrl and mad_datapath.
module ms_adpcm_stream_decoder_unit import mad_pkg::*; #(
	parameter int MAX_CHANNELS = 2
) (
	input logic       clk,
	input logic       arst_n,
	mad_byte_if.sink  adpcm,
	mad_pcm_if.source pcm,
	mad_cfg_if.sink   cfg
);

	mad_cmd_t cmd;
	mad_sts_t sts;
	logic     in_ready;

	// Configuration is always accepted
	assign cfg.ready   = 1'b1;
	assign adpcm.ready = in_ready;

	mad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (adpcm.valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	mad_datapath #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.data_byte   (adpcm.data_byte),
		.chunk_start (adpcm.chunk_start),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (pcm.valid),
		.out_ready   (pcm.ready),
		.out_sample  (pcm.sample),
		.out_channel (pcm.channel),
		.out_last    (pcm.last)
	);

endmodule

FILE: tb/tb_ms_adpcm_stream_decoder_unit.sv
`timescale 1ns / 100ps
// Testbench for ms_adpcm_stream_decoder_unit: feeds ADPCM chunk bytes, predicts the
// decoded PCM samples per byte and checks every sample transfer in order.
// Depends on mad_pkg, mad_stream_ifs and the decoder RTL.
module tb_ms_adpcm_stream_decoder_unit import mad_pkg::*; ();

	localparam int NCH_MAX     = 2;
	localparam int STALL_LIMIT = 5000;  // cycles with no transfer on any channel
	localparam int SETTLE      = 12;    // margin for the last byte to finish inside the block
	localparam int RX_HOLD     = 500;   // long receiver hold-off

	// Directed blocks, mono with block_align 8: predictor byte, step, newer, older, one data byte
	localparam logic [24*8-1:0] DIRECTED = {
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h7F,
		8'h01, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h80,
		8'h07, 8'h00, 8'h80, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_start;
	} adpcm_byte_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               channel;
		logic               last;
	} pcm_word_t;

	// One byte waiting to be sent, with the samples it will produce
	typedef struct {
		adpcm_byte_t b;
		int          n;
		pcm_word_t   hi;
		pcm_word_t   lo;
	} byte_job_t;

	typedef enum int {HB_PRED, HB_STEP_HI, HB_OTHER, HB_DATA} byte_kind_t;

	logic clk;
	logic arst_n;

	mad_byte_if adpcm_ch ();
	mad_pcm_if  pcm_ch ();
	mad_cfg_if  cfg_ch ();

	ms_adpcm_stream_decoder_unit #(.MAX_CHANNELS(NCH_MAX)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.adpcm  (adpcm_ch),
		.pcm    (pcm_ch),
		.cfg    (cfg_ch)
	);

	byte_job_t byte_jobs[$];
	pcm_word_t pcm_due[$];
	byte_job_t taken_job;
	pcm_word_t want;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_reqs;
	int hold_seen;
	int hold_left;
	int quiet_cycles;
	int errors;
	int bytes_taken;
	int samples_checked;
	int settings_run;

	// Decoder model state
	logic [1:0]  m_channels;
	logic [15:0] m_align;
	logic [15:0] m_pos;
	int          m_ch;
	logic [7:0]  m_low;
	logic [2:0]  m_pi   [NCH_MAX];
	logic [15:0] m_step [NCH_MAX];
	logic [15:0] m_new  [NCH_MAX];
	logic [15:0] m_old  [NCH_MAX];
	bit          got_pi [NCH_MAX];
	bit          got_step [NCH_MAX];
	bit          got_new [NCH_MAX];
	bit          got_old [NCH_MAX];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int active_ch();
		if (m_channels == 2'd0)
			return 1;
		if (m_channels > NCH_MAX)
			return NCH_MAX;
		return int'(m_channels);
	endfunction

	function automatic void pick_coefs(input logic [2:0] pi, output int ca, output int cb);
		case (pi)
			3'd0: begin ca = 256; cb = 0; end
			3'd1: begin ca = 512; cb = -256; end
			3'd2: begin ca = 0;   cb = 0; end
			3'd3: begin ca = 192; cb = 64; end
			3'd4: begin ca = 240; cb = 0; end
			3'd5: begin ca = 460; cb = -208; end
			default: begin ca = 392; cb = -232; end
		endcase
	endfunction

	function automatic int adapt_of(input logic [3:0] nib);
		case (nib) inside
			4'd4, 4'd12: return 307;
			4'd5, 4'd11: return 409;
			4'd6, 4'd10: return 512;
			4'd7, 4'd9:  return 614;
			4'd8:        return 768;
			default:     return 230;
		endcase
	endfunction

	// Where a byte at this block position lands
	function automatic byte_kind_t kind_at(input int pos, input int nch);
		int q;
		if (pos >= 7 * nch)
			return HB_DATA;
		if (pos < nch)
			return HB_PRED;
		q = pos - nch;
		if (q[0] && q < 2 * nch)
			return HB_STEP_HI;
		return HB_OTHER;
	endfunction

	// Header capture: predictor bytes, then 16-bit step, newer, older per channel
	function automatic void take_header(input int pos, input logic [7:0] b, input int nch);
		int q;
		int ch;
		logic [15:0] w;
		if (pos < nch) begin
			m_pi[pos] = (b > 8'd6) ? 3'd6 : b[2:0];
			got_pi[pos] = 1'b1;
		end else begin
			q = pos - nch;
			ch = (q >> 1) % nch;
			if (!q[0]) begin
				m_low = b;
			end else begin
				w = {b, m_low};
				if (q < 2 * nch) begin
					m_step[ch] = w;
					got_step[ch] = 1'b1;
				end else if (q < 4 * nch) begin
					m_new[ch] = w;
					got_new[ch] = 1'b1;
				end else begin
					m_old[ch] = w;
					got_old[ch] = 1'b1;
				end
			end
		end
	endfunction

	// One nibble: predict, add scaled nibble, clamp, adapt step
	function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib, input int ch);
		int ca, cb, h_new, h_old, step, sn, s, t;
		pick_coefs(m_pi[ch], ca, cb);
		h_new = $signed(m_new[ch]);
		h_old = $signed(m_old[ch]);
		step = $signed(m_step[ch]);
		sn = $signed(nib);
		s = (h_new * ca + h_old * cb) / 256;
		s += sn * step;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		m_old[ch] = m_new[ch];
		m_new[ch] = s[15:0];
		t = adapt_of(nib) * step / 256;
		m_step[ch] = t[15:0];
		if ($signed(m_step[ch]) < 16)
			m_step[ch] = 16'd16;
		return s[15:0];
	endfunction

	// Advance the model by one byte and collect the samples it gives
	function automatic byte_job_t decode_byte(input adpcm_byte_t it);
		byte_job_t j;
		pcm_word_t w;
		int nch;
		int pos;
		logic [3:0] nib;
		j.b = it;
		j.n = 0;
		j.hi = '0;
		j.lo = '0;
		nch = active_ch();
		if (it.chunk_start) begin
			m_pos = 16'd0;
			m_ch = 0;
		end
		if (m_ch >= nch)
			m_ch = 0;
		pos = int'(m_pos);
		if (pos < 7 * nch) begin
			take_header(pos, it.data_byte, nch);
		end else begin
			for (int k = 0; k < 2; k++) begin
				nib = (k == 0) ? it.data_byte[7:4] : it.data_byte[3:0];
				w.sample = decode_nibble(nib, m_ch);
				w.channel = m_ch[0];
				w.last = (k == 1);
				if (k == 0)
					j.hi = w;
				else
					j.lo = w;
				j.n++;
				m_ch = (m_ch + 1 < nch) ? m_ch + 1 : 0;
			end
		end
		m_pos = m_pos + 16'd1;
		if (m_pos == m_align)
			m_pos = 16'd0;
		return j;
	endfunction

	// True when this byte would decode a channel whose header never arrived
	function automatic bit hits_unwritten(input adpcm_byte_t it);
		int nch;
		int pos;
		int ch;
		nch = active_ch();
		pos = it.chunk_start ? 0 : int'(m_pos);
		ch = (it.chunk_start || m_ch >= nch) ? 0 : m_ch;
		if (pos < 7 * nch)
			return 1'b0;
		for (int k = 0; k < 2; k++) begin
			if (!(got_pi[ch] && got_step[ch] && got_new[ch] && got_old[ch]))
				return 1'b1;
			ch = (ch + 1 < nch) ? ch + 1 : 0;
		end
		return 1'b0;
	endfunction

	// Random byte shaped by its place in the block; chunk_start breaks the block now and then
	function automatic adpcm_byte_t make_byte(input int break_pm, input bit fresh);
		adpcm_byte_t it;
		int pos;
		it.data_byte = 8'h00;
		it.chunk_start = fresh || ($urandom_range(999) < break_pm);
		if (hits_unwritten(it))
			it.chunk_start = 1'b1;
		pos = it.chunk_start ? 0 : int'(m_pos);
		case (kind_at(pos, active_ch()))
			HB_PRED:
				it.data_byte = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) :
					8'($urandom_range(6));
			HB_STEP_HI:
				it.data_byte = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
					8'($urandom_range(7));
			default:
				it.data_byte = 8'($urandom_range(255));
		endcase
		return it;
	endfunction

	task automatic queue_byte(input adpcm_byte_t it);
		byte_jobs.push_back(decode_byte(it));
	endtask

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	// Block is idle once nothing is pending and a settling margin has passed
	task automatic wait_drained();
		while (byte_jobs.size() != 0 || pcm_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_CHANNELS)
			m_channels = val[1:0];
		else if (idx == CFG_BLOCK_ALIGN)
			m_align = val;
	endtask

	task automatic run_phase(input logic [1:0] nch, input logic [15:0] align, input int count,
			input int tx_pct, input int rx_pct, input int break_pm, input bit fresh);
		wait_drained();
		write_reg(CFG_CHANNELS, {{(CFG_DATA_W-2){1'b0}}, nch});
		write_reg(CFG_BLOCK_ALIGN, align);
		settings_run++;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < count; i++) begin
			queue_byte(make_byte(break_pm, fresh && i == 0));
			// sender pause in the middle of longer phases
			if (count >= 200 && i == count / 2)
				wait_drained();
		end
	endtask

	// Byte driver: holds an offered byte until transfer, idles at random between bytes
	always @(posedge clk) begin
		if (!arst_n) begin
			adpcm_ch.valid <= 1'b0;
		end else begin
			if (adpcm_ch.valid && adpcm_ch.ready) begin
				taken_job = byte_jobs.pop_front();
				if (taken_job.n > 0)
					pcm_due.push_back(taken_job.hi);
				if (taken_job.n > 1)
					pcm_due.push_back(taken_job.lo);
				bytes_taken++;
			end
			if (!(adpcm_ch.valid && !adpcm_ch.ready)) begin
				if (byte_jobs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					adpcm_ch.valid       <= 1'b1;
					adpcm_ch.data_byte   <= byte_jobs[0].b.data_byte;
					adpcm_ch.chunk_start <= byte_jobs[0].b.chunk_start;
				end else begin
					adpcm_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Sample monitor: checks each transfer against the oldest expected sample
	always @(posedge clk) begin
		if (!arst_n) begin
			pcm_ch.ready <= 1'b0;
		end else begin
			if (pcm_ch.valid && pcm_ch.ready) begin
				if (pcm_due.size() == 0) begin
					flag_error($sformatf("unexpected sample %0d ch %0d last %0d",
						pcm_ch.sample, pcm_ch.channel, pcm_ch.last));
				end else begin
					want = pcm_due.pop_front();
					samples_checked++;
					if (pcm_ch.sample !== want.sample || pcm_ch.channel !== want.channel ||
							pcm_ch.last !== want.last)
						flag_error($sformatf(
							"mismatch at sample %0d: expected %0d ch %0d last %0d, got %0d ch %0d last %0d",
							samples_checked, want.sample, want.channel, want.last,
							pcm_ch.sample, pcm_ch.channel, pcm_ch.last));
				end
			end
			// long hold-off on request, random idling otherwise
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = RX_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pcm_ch.ready <= 1'b0;
			end else begin
				pcm_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((adpcm_ch.valid && adpcm_ch.ready) || (pcm_ch.valid && pcm_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d samples still due",
					quiet_cycles, pcm_due.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		adpcm_ch.valid = 1'b0;
		adpcm_ch.data_byte = 8'h00;
		adpcm_ch.chunk_start = 1'b0;
		pcm_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_CHANNELS;
		cfg_ch.data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_reqs = 0;
		hold_seen = 0;
		hold_left = 0;
		quiet_cycles = 0;
		errors = 0;
		bytes_taken = 0;
		samples_checked = 0;
		settings_run = 0;
		m_channels = CHANNELS_RST;
		m_align = BLOCK_ALIGN_RST;
		m_pos = 16'd0;
		m_ch = 0;
		m_low = 8'h00;
		for (int c = 0; c < NCH_MAX; c++) begin
			m_pi[c] = 3'd0;
			m_step[c] = 16'd0;
			m_new[c] = 16'd0;
			m_old[c] = 16'd0;
			got_pi[c] = 1'b0;
			got_step[c] = 1'b0;
			got_new[c] = 1'b0;
			got_old[c] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: mono blocks of 8 bytes, predictor above six, extreme steps and history
		run_phase(2'd1, 16'd8, 0, 34, 86, 0, 1'b0);
		for (int i = 0; i < 24; i++)
			queue_byte('{data_byte: DIRECTED[8*(23-i) +: 8], chunk_start: (i == 0)});

		// receiver idles more than sender first, then the other way round
		run_phase(2'd2, 16'd256,   250, 34, 86, 3, 1'b1);
		run_phase(2'd1, 16'd64,    200, 34, 86, 3, 1'b0);
		run_phase(2'd0, 16'd65535, 120, 86, 34, 3, 1'b0);  // zero channels acts as mono
		run_phase(2'd3, 16'd15,    200, 86, 34, 3, 1'b0);  // above the maximum, smallest stereo block
		run_phase(2'd2, 16'd14,     30, 86, 34, 3, 1'b0);  // block all header, no samples
		run_phase(2'd2, 16'd0,     150,  0,  0, 3, 1'b0);  // position wraps only past 65535
		run_phase(2'd1, 16'd400,   120,  0,  0, 0, 1'b1);
		run_phase(2'd1, 16'd20,    100,  0,  0, 0, 1'b0);  // align lowered below the position
		hold_reqs++;
		run_phase(2'd2, 16'd1024,  250,  0,  0, 3, 1'b1);

		wait_drained();
		$display("Run summary: %0d bytes taken, %0d samples checked over %0d register settings",
			bytes_taken, samples_checked, settings_run);
		$display("Mismatch count: %0d", errors);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
